// ----- rtl/core/hsort_pkg.sv -----
// Shared types and defaults of the in-place min-heap sorter.
// No dependencies; hsort_cmp, hsort_seq and the top level import this package.
package hsort_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_SRT,
    ST_SRT_SWAP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_EM_RD,
    ST_EM_WR
  } hs_state_t;

  // Which operand the compare unit found smallest
  typedef enum logic [1:0] {
    PICK_X,
    PICK_A,
    PICK_B
  } pick_t;

  // Sequencer to output register
  typedef struct packed {
    logic load;
    logic last;
  } emit_ctl_t;

endpackage

// ----- rtl/core/hsort_in_if.sv -----
// Input channel of the heap sorter: valid/ready plus value and last flag.
// Standalone interface, no package dependency.
interface hsort_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- rtl/core/hsort_out_if.sv -----
// Result channel of the heap sorter: valid/ready plus sorted value and last flag.
// Standalone interface, no package dependency.
interface hsort_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value_res;
  logic                         last_res;

  modport source (output valid, output value_res, output last_res, input ready);
  modport sink   (input valid, input value_res, input last_res, output ready);
endinterface

// ----- rtl/core/hsort_mem.sv -----
// Heap store: one write port, two read ports with registered read data.
// Depends on nothing but its parameters.
module hsort_mem #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 6
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [AW-1:0]         rd_addr_a,
  input  logic [AW-1:0]         rd_addr_b,
  output logic [DATA_WIDTH-1:0] rd_data_a,
  output logic [DATA_WIDTH-1:0] rd_data_b
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- rtl/core/hsort_cmp.sv -----
// Shared signed compare unit: smallest of x, a and (optionally) b.
// Uses hsort_pkg::pick_t. Ties keep the earlier operand.
module hsort_cmp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic [DATA_WIDTH-1:0] x,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  input  logic                  b_ok,
  output hsort_pkg::pick_t      pick,
  output logic [DATA_WIDTH-1:0] min_val
);
  import hsort_pkg::*;

  logic [DATA_WIDTH-1:0] best_xa;
  pick_t                 pick_xa;

  always_comb begin
    if ($signed(a) < $signed(x)) begin
      best_xa = a;
      pick_xa = PICK_A;
    end else begin
      best_xa = x;
      pick_xa = PICK_X;
    end
    if (b_ok && ($signed(b) < $signed(best_xa))) begin
      min_val = b;
      pick    = PICK_B;
    end else begin
      min_val = best_xa;
      pick    = pick_xa;
    end
  end

endmodule

// ----- rtl/core/hsort_seq.sv -----
// Sequencer of the heap sorter: sift-up on insert, root extraction with
// sift-down, then read-out. Uses hsort_pkg; drives hsort_mem and hsort_cmp.
module hsort_seq #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 6,
  parameter int CW         = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_valid,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic                  in_last,
  output logic                  in_ready,
  // output register
  input  logic                  out_free,
  output hsort_pkg::emit_ctl_t  emit,
  output logic [DATA_WIDTH-1:0] emit_value,
  // heap store
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [DATA_WIDTH-1:0] wr_data,
  output logic [AW-1:0]         rd_addr_a,
  output logic [AW-1:0]         rd_addr_b,
  input  logic [DATA_WIDTH-1:0] rd_data_a,
  input  logic [DATA_WIDTH-1:0] rd_data_b,
  // compare unit
  output logic [DATA_WIDTH-1:0] cmp_x,
  output logic [DATA_WIDTH-1:0] cmp_a,
  output logic [DATA_WIDTH-1:0] cmp_b,
  output logic                  cmp_b_ok,
  input  hsort_pkg::pick_t      cmp_pick,
  input  logic [DATA_WIDTH-1:0] cmp_min
);
  import hsort_pkg::*;

  localparam int IW = AW + 2;

  hs_state_t             state_r, state_nxt;
  logic [DATA_WIDTH-1:0] v_r, v_nxt;        // element being sifted (hole value)
  logic                  last_r, last_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         size_r, size_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;    // hole position
  logic [AW-1:0]         walk_r, walk_nxt;

  logic [IW-1:0] left, right, size_ext;
  logic [AW-1:0] parent;
  logic [CW-1:0] sz_m1;
  logic          ins_done;
  logic          em_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      size_r  <= '0;
      walk_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      size_r  <= size_nxt;
      walk_r  <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    last_r <= last_nxt;
    pos_r  <= pos_nxt;
  end

  assign left       = {1'b0, pos_r, 1'b1};
  assign right      = left + IW'(1);
  assign size_ext   = IW'(size_r);
  assign parent     = (pos_r - AW'(1)) >> 1;
  assign sz_m1      = size_r - CW'(1);
  assign em_last    = ((CW'(walk_r) + CW'(1)) == count_r);
  assign emit_value = rd_data_a;

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    last_nxt  = last_r;
    count_nxt = count_r;
    size_nxt  = size_r;
    pos_nxt   = pos_r;
    walk_nxt  = walk_r;
    wr_en     = 1'b0;
    wr_addr   = pos_r;
    wr_data   = v_r;
    rd_addr_a = pos_r;
    rd_addr_b = pos_r;
    cmp_x     = rd_data_a;
    cmp_a     = v_r;
    cmp_b     = rd_data_b;
    cmp_b_ok  = 1'b0;
    in_ready  = 1'b0;
    emit      = '0;
    ins_done  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          v_nxt    = in_value;
          last_nxt = in_last;
          if (count_r != CW'(DEPTH)) begin
            pos_nxt   = count_r[AW-1:0];
            state_nxt = ST_UP_RD;
          end else if (in_last) begin
            // store full: word dropped, sort what is held
            size_nxt  = count_r;
            state_nxt = ST_SRT;
          end
        end
      end
      ST_UP_RD: begin
        if (pos_r == '0) begin
          wr_en    = 1'b1;
          ins_done = 1'b1;
        end else begin
          rd_addr_a = parent;
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        // parent moves down into the hole if new value is smaller
        wr_en = 1'b1;
        if (cmp_pick == PICK_A) begin
          wr_data   = rd_data_a;
          pos_nxt   = parent;
          state_nxt = ST_UP_RD;
        end else begin
          ins_done = 1'b1;
        end
      end
      ST_SRT: begin
        if (size_r <= CW'(1)) begin
          walk_nxt  = '0;
          state_nxt = ST_EM_RD;
        end else begin
          rd_addr_a = '0;
          rd_addr_b = sz_m1[AW-1:0];
          state_nxt = ST_SRT_SWAP;
        end
      end
      ST_SRT_SWAP: begin
        // root goes to the end; former last entry sifts down from the root
        wr_en     = 1'b1;
        wr_addr   = sz_m1[AW-1:0];
        wr_data   = rd_data_a;
        v_nxt     = rd_data_b;
        size_nxt  = sz_m1;
        pos_nxt   = '0;
        state_nxt = ST_DN_RD;
      end
      ST_DN_RD: begin
        if (left >= size_ext) begin
          wr_en     = 1'b1;
          state_nxt = ST_SRT;
        end else begin
          rd_addr_a = left[AW-1:0];
          rd_addr_b = right[AW-1:0];
          state_nxt = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        cmp_x    = v_r;
        cmp_a    = rd_data_a;
        cmp_b    = rd_data_b;
        cmp_b_ok = (right < size_ext);
        wr_en    = 1'b1;
        unique case (cmp_pick)
          PICK_X: begin
            state_nxt = ST_SRT;
          end
          PICK_A: begin
            wr_data   = cmp_min;
            pos_nxt   = left[AW-1:0];
            state_nxt = ST_DN_RD;
          end
          PICK_B: begin
            wr_data   = cmp_min;
            pos_nxt   = right[AW-1:0];
            state_nxt = ST_DN_RD;
          end
          default: begin
            state_nxt = ST_SRT;
          end
        endcase
      end
      ST_EM_RD: begin
        rd_addr_a = walk_r;
        state_nxt = ST_EM_WR;
      end
      ST_EM_WR: begin
        rd_addr_a = walk_r;
        if (out_free) begin
          emit.load = 1'b1;
          emit.last = em_last;
          if (em_last) begin
            count_nxt = '0;
            size_nxt  = '0;
            walk_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            walk_nxt  = walk_r + AW'(1);
            state_nxt = ST_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (ins_done) begin
      count_nxt = count_r + CW'(1);
      if (last_r) begin
        size_nxt  = count_r + CW'(1);
        state_nxt = ST_SRT;
      end else begin
        state_nxt = ST_IDLE;
      end
    end
  end

endmodule

// ----- rtl/core/in_place_min_heap_sort_core.sv -----
// In-place min-heap sorter, top level.
// Collects a set of signed words on in_ch, one per handshake; the word with
// last set closes the set. Each word is written at the end of the heap store
// and sifted up (min-heap). On the last word the block repeatedly moves the
// root to the end of the shrinking heap and sifts down, leaving the store in
// descending order, then sends it on out_ch, last_res set on the final word.
// Words beyond DEPTH are dropped; a last flag on a dropped word still sorts.
// On insert a word climbs at most log2 DEPTH levels of the heap.
// All of it runs on one shared compare unit against a 1W/2R store, and in_ch
// is not ready while a word is being inserted, sorted or sent.
// out_ch has an output register: a stalled receiver holds the sequencer in
// its send state with the word held, nothing is lost. After the final word is
// loaded, in_ch is ready again while that word waits to be taken.
// Reset (rst_n low, synchronous) empties the set and the output register.
// The store itself is not cleared; only entries written in this set are read.
module in_place_min_heap_sort_core #(
  parameter int DEPTH      = hsort_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = hsort_pkg::DATA_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  hsort_in_if.sink   in_ch,
  hsort_out_if.source out_ch
);
  import hsort_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // store port
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         rd_addr_a, rd_addr_b;
  logic [DATA_WIDTH-1:0] rd_data_a, rd_data_b;

  // compare unit
  logic [DATA_WIDTH-1:0] cmp_x, cmp_a, cmp_b, cmp_min;
  logic                  cmp_b_ok;
  pick_t                 cmp_pick;

  // output register
  emit_ctl_t             emit;
  logic [DATA_WIDTH-1:0] emit_value;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_value_r, out_value_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_free;

  hsort_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  hsort_cmp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cmp (
    .x       (cmp_x),
    .a       (cmp_a),
    .b       (cmp_b),
    .b_ok    (cmp_b_ok),
    .pick    (cmp_pick),
    .min_val (cmp_min)
  );

  hsort_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_value   (in_ch.value),
    .in_last    (in_ch.last),
    .in_ready   (in_ch.ready),
    .out_free   (out_free),
    .emit       (emit),
    .emit_value (emit_value),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b),
    .rd_data_a  (rd_data_a),
    .rd_data_b  (rd_data_b),
    .cmp_x      (cmp_x),
    .cmp_a      (cmp_a),
    .cmp_b      (cmp_b),
    .cmp_b_ok   (cmp_b_ok),
    .cmp_pick   (cmp_pick),
    .cmp_min    (cmp_min)
  );

  // register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit.load) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = emit_value;
      out_last_nxt  = emit.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_res = out_value_r;
  assign out_ch.last_res  = out_last_r;

  // never overwrite a word the receiver has not taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load |-> (!out_valid_r || out_ch.ready))
    else $error("output word overwritten while stalled");

  // a closing word starts sorting, so input must drop next cycle
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last) |=> !in_ch.ready)
    else $error("input ready right after closing word");

  // output valid only rises from a sequencer load
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(emit.load))
    else $error("output valid without load");

  // no new input while a run is being sent
  a_no_input_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.load && !emit.last) |-> !in_ch.ready)
    else $error("input ready during read-out");

endmodule
